// ===== rtl/core/btr_pkg.sv =====
// Shared types, screen constants and the 4x6 font ROM for the bitmap text rasterizer.
// No dependencies; imported by btr_pixel_unit and bitmap_text_rasterizer_core.
package btr_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 160;

  // Font and pen constants
  localparam int FIRST_CODE  = 32;
  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_BITS  = 24;
  localparam int PEN_ADVANCE = 5;
  localparam logic signed [15:0] PEN_MAX = 16'sd32767;
  localparam logic signed [15:0] PEN_SAT_LIMIT = 16'sd32762;

  localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
  localparam int BIT_IDX_W   = $clog2(GLYPH_BITS);

  // Result of one pixel evaluation
  typedef struct packed {
    logic        visible;
    logic [15:0] address;
  } btr_pix_t;

  // Glyphs for codes 32..127, row-major, MSB is row 0 column 0
  localparam logic [23:0] GLYPH_ROM [GLYPH_COUNT] = '{
    24'h000000, 24'h444040, 24'hAA0000, 24'h5F5F50,
    24'h6EC760, 24'h936490, 24'h4A4AD0, 24'h440000,
    24'h244420, 24'h422240, 24'h0A4A00, 24'h04E400,
    24'h000024, 24'h00E000, 24'h000040, 24'h124480,
    24'h69BD96, 24'h262227, 24'h69248F, 24'hE1611E,
    24'h99F111, 24'hF8E11E, 24'h68E996, 24'hF12444,
    24'h696996, 24'h699716, 24'h040400, 24'h040424,
    24'h124842, 24'h0E0E00, 24'h421248, 24'h692020,
    24'h6BDB87, 24'h699F99, 24'hE9E99E, 24'h698896,
    24'hE9999E, 24'hF8E88F, 24'hF8E888, 24'h698B96,
    24'h99F999, 24'hE4444E, 24'h711196, 24'h9ACA99,
    24'h88888F, 24'h9FF999, 24'h9DBB99, 24'h699996,
    24'hE99E88, 24'h699B95, 24'hE99EA9, 24'h69861E,
    24'hE44444, 24'h999996, 24'h999966, 24'h999FF9,
    24'h996999, 24'h996444, 24'hF1248F, 24'h644446,
    24'h844221, 24'h622226, 24'h690000, 24'h00000F,
    24'h420000, 24'h699F99, 24'hE9E99E, 24'h698896,
    24'hE9999E, 24'hF8E88F, 24'hF8E888, 24'h698B96,
    24'h99F999, 24'hE4444E, 24'h711196, 24'h9ACA99,
    24'h88888F, 24'h9FF999, 24'h9DBB99, 24'h699996,
    24'hE99E88, 24'h699B95, 24'hE99EA9, 24'h69861E,
    24'hE44444, 24'h999996, 24'h999966, 24'h999FF9,
    24'h996999, 24'h996444, 24'hF1248F, 24'h248442,
    24'h444444, 24'h421424, 24'h05A000, 24'h000000
  };

  // Fetch the glyph of a character byte; codes outside 32..127 are blank
  function automatic logic [23:0] glyph_lookup(input logic [7:0] code);
    logic [GLYPH_IDX_W-1:0] idx;
    idx = GLYPH_IDX_W'(code[6:0] - 7'(FIRST_CODE));
    if (!code[7] && (code[6:5] != 2'b00)) begin
      return GLYPH_ROM[idx];
    end
    return 24'h000000;
  endfunction

endpackage

// ===== rtl/core/btr_if.sv =====
// Valid/ready channel interfaces for character requests and pixel write requests.
// No dependencies.
interface btr_char_if;
  logic               valid;
  logic               ready;
  logic [7:0]         char_code;
  logic               string_start;
  logic signed [10:0] start_x;
  logic signed [10:0] row_y;
  logic [14:0]        pixel_color;

  modport source (output valid, char_code, string_start, start_x, row_y, pixel_color,
                  input ready);
  modport sink (input valid, char_code, string_start, start_x, row_y, pixel_color,
                output ready);
endinterface

interface btr_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_address;
  logic [14:0] write_color;
  logic        last_write;

  modport source (output valid, pixel_address, write_color, last_write, input ready);
  modport sink (input valid, pixel_address, write_color, last_write, output ready);
endinterface

// ===== rtl/core/btr_pixel_unit.sv =====
// Shared pixel unit: clips one glyph pixel against the screen and forms its address.
// Depends on btr_pkg.
module btr_pixel_unit
  import btr_pkg::*;
(
  input  logic signed [15:0] draw_x,
  input  logic signed [10:0] top_y,
  input  logic [15:0]        row_addr,
  input  logic [1:0]         col,
  input  logic [2:0]         row,
  output btr_pix_t           pix
);

  logic signed [16:0] px;
  logic signed [11:0] py;
  logic               x_ok;
  logic               y_ok;

  // Place the pixel relative to pen and text line
  assign px = 17'(draw_x) + $signed({15'd0, col});
  assign py = 12'(top_y) + $signed({9'd0, row});

  // Clip against the screen
  assign x_ok = !px[16] && (px[15:0] < 16'(SCREEN_WIDTH));
  assign y_ok = !py[11] && (py[10:0] < 11'(SCREEN_HEIGHT));

  assign pix.visible = x_ok && y_ok;
  assign pix.address = row_addr + px[15:0];

endmodule

// ===== rtl/core/bitmap_text_rasterizer_core.sv =====
// Bitmap text rasterizer top level: 4x6 character generator emitting pixel write requests.
// Each character is accepted in the idle state, its 24 glyph bits are then stepped through
// the shared pixel unit, and a final flush state follows; a new character is accepted only
// after the flush, and steps stall while the output side stalls.
// Reset (rst, synchronous): pen column cleared to 0, sequencer idle, output empty.
// Depends on btr_pkg, btr_if and btr_pixel_unit.
module bitmap_text_rasterizer_core
  import btr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  btr_char_if.sink     char_in,
  btr_pixel_if.source  pixel_out
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [15:0] WIDTH16 = 16'(SCREEN_WIDTH);

  logic [1:0]           state;
  logic signed [15:0]   pen_x;
  logic signed [15:0]   pen_x_next;
  logic signed [15:0]   draw_x;
  logic signed [15:0]   draw_x_next;
  logic signed [10:0]   top_y;
  logic [15:0]          row_addr;
  logic [14:0]          color;
  logic [23:0]          glyph;
  logic [BIT_IDX_W-1:0] bit_idx;

  // One pending write held back until it is known whether it is the last
  logic                 pend_valid;
  logic [15:0]          pend_address;

  // Output register
  logic                 out_valid;
  logic [15:0]          out_address;
  logic [14:0]          out_color;
  logic                 out_last;

  btr_pix_t             pix;
  logic                 accept;
  logic                 out_free;
  logic                 hit;
  logic                 step;

  btr_pixel_unit u_pixel (
    .draw_x   (draw_x),
    .top_y    (top_y),
    .row_addr (row_addr),
    .col      (bit_idx[1:0]),
    .row      (bit_idx[4:2]),
    .pix      (pix)
  );

  assign char_in.ready = (state == ST_IDLE);
  assign accept        = char_in.valid && char_in.ready;
  assign out_free      = !out_valid || pixel_out.ready;
  assign hit           = glyph[23] && pix.visible;
  // Stall a step only when a new hit must push out the pending write and the output is full
  assign step          = !(hit && pend_valid && !out_free);

  // Select the drawing column and saturate the advanced pen
  always_comb begin
    draw_x_next = char_in.string_start ? 16'(char_in.start_x) : pen_x;
    if (draw_x_next > PEN_SAT_LIMIT) begin
      pen_x_next = PEN_MAX;
    end else begin
      pen_x_next = draw_x_next + 16'sd5;
    end
  end

  // Sequencer and scan datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pen_x      <= '0;
      pend_valid <= 1'b0;
      bit_idx    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pen_x    <= pen_x_next;
            draw_x   <= draw_x_next;
            top_y    <= char_in.row_y;
            row_addr <= 16'({{5{char_in.row_y[10]}}, char_in.row_y} * WIDTH16);
            color    <= char_in.pixel_color;
            glyph    <= glyph_lookup(char_in.char_code);
            bit_idx  <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (step) begin
            if (hit) begin
              pend_valid   <= 1'b1;
              pend_address <= pix.address;
            end
            glyph <= {glyph[22:0], 1'b0};
            if (bit_idx[1:0] == 2'd3) begin
              row_addr <= row_addr + WIDTH16;
            end
            if (bit_idx == BIT_IDX_W'(GLYPH_BITS - 1)) begin
              state <= ST_FLUSH;
            end else begin
              bit_idx <= bit_idx + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Load the output register from the pending write, or drain it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_SCAN) && hit && pend_valid && out_free) begin
      out_valid   <= 1'b1;
      out_address <= pend_address;
      out_color   <= color;
      out_last    <= 1'b0;
    end else if ((state == ST_FLUSH) && pend_valid && out_free) begin
      out_valid   <= 1'b1;
      out_address <= pend_address;
      out_color   <= color;
      out_last    <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign pixel_out.valid         = out_valid;
  assign pixel_out.pixel_address = out_address;
  assign pixel_out.write_color   = out_color;
  assign pixel_out.last_write    = out_last;

endmodule
